/* src/bwfvf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bwfvf_pkg
// Shared types, widths and helpers for the Butterworth Fourier volume filter.
// ----------------------------------------------------------------------------
package bwfvf_pkg;

  localparam int MAX_GRID       = 512;
  localparam int GAIN_FRAC_BITS = 16;

  localparam int GRID_W  = 10;                       // grid_size field width
  localparam int POS_W   = $clog2(MAX_GRID);          // position counters
  localparam int FREQ_W  = GRID_W + 1;                // signed frequency index
  localparam int R2_W    = 2 * POS_W + 2;             // squared radius
  localparam int CFG_W   = 32;
  localparam int COEF_W  = 32;
  localparam int MUL_W   = 33;                        // shared signed multiplier
  localparam int PROD_W  = 2 * MUL_W;
  localparam int T_W     = 33;                        // x, x2, x4 register
  localparam int D_W     = 49;                        // denominator 1 + x^8
  localparam int QW      = 2 * GAIN_FRAC_BITS + 1;    // quotient bits
  localparam int SQ_W    = QW + 1;                    // root work registers
  localparam int GAIN_W  = GAIN_FRAC_BITS + 2;        // signed gain
  localparam int CNT_W   = $clog2(QW + 1);

  typedef enum logic [1:0] {
    REG_GRID_SIZE   = 2'd0,
    REG_FILTER_MODE = 2'd1,
    REG_HIGH_CUT    = 2'd2,
    REG_LOW_CUT     = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD,
    OP_MUL_X, OP_SET_X, OP_MUL_X2, OP_SET_X2, OP_MUL_X4, OP_SET_X4,
    OP_MUL_HH, OP_ACC_HH, OP_MUL_HL, OP_ACC_HL, OP_MUL_LL, OP_ACC_LL,
    OP_DIV_STEP, OP_SQRT_INIT, OP_SQRT_STEP, OP_GAIN,
    OP_MUL_RE, OP_SET_RE, OP_MUL_IM, OP_OUT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL_X, S_SET_X, S_MUL_X2, S_SET_X2, S_MUL_X4, S_SET_X4,
    S_MUL_HH, S_ACC_HH, S_MUL_HL, S_ACC_HL, S_MUL_LL, S_ACC_LL,
    S_DIV, S_SQRT_INIT, S_SQRT, S_GAIN,
    S_MUL_RE, S_SET_RE, S_MUL_IM, S_OUT
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   sel_low;    // second gain pass, low cutoff
  } dp_cmd_t;

  typedef struct packed {
    logic mode_bp;      // band-pass selected
    logic out_busy;     // result register full and stalled
  } dp_stat_t;

  // Round half up at the gain point, then saturate to 32 bits.
  function automatic logic signed [COEF_W-1:0] scale_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] v;
    logic signed [PROD_W-1:0] q;
    v = p + (PROD_W'(1) <<< (GAIN_FRAC_BITS - 1));
    q = v >>> GAIN_FRAC_BITS;
    if (q > PROD_W'(64'sd2147483647)) begin
      scale_sat = 32'sh7FFFFFFF;
    end else if (q < -PROD_W'(64'sd2147483648)) begin
      scale_sat = 32'sh80000000;
    end else begin
      scale_sat = q[COEF_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* src/bwfvf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bwfvf_ctrl
// Sequencer: steps the datapath through ratio, powers, divide, root and scale.
// ----------------------------------------------------------------------------
module bwfvf_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire bwfvf_pkg::dp_stat_t  stat,
  output bwfvf_pkg::dp_cmd_t        cmd
);

  bwfvf_pkg::state_t                 state_r, state_nxt;
  logic [bwfvf_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                              pass_r, pass_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bwfvf_pkg::S_IDLE;
      cnt_r   <= '0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    pass_nxt    = pass_r;
    cmd.op      = bwfvf_pkg::OP_NONE;
    cmd.sel_low = pass_r;
    in_stall    = (state_r != bwfvf_pkg::S_IDLE);
    case (state_r)
      bwfvf_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op    = bwfvf_pkg::OP_LOAD;
          pass_nxt  = 1'b0;
          state_nxt = bwfvf_pkg::S_MUL_X;
        end
      end
      bwfvf_pkg::S_MUL_X: begin
        cmd.op = bwfvf_pkg::OP_MUL_X;  state_nxt = bwfvf_pkg::S_SET_X;
      end
      bwfvf_pkg::S_SET_X: begin
        cmd.op = bwfvf_pkg::OP_SET_X;  state_nxt = bwfvf_pkg::S_MUL_X2;
      end
      bwfvf_pkg::S_MUL_X2: begin
        cmd.op = bwfvf_pkg::OP_MUL_X2; state_nxt = bwfvf_pkg::S_SET_X2;
      end
      bwfvf_pkg::S_SET_X2: begin
        cmd.op = bwfvf_pkg::OP_SET_X2; state_nxt = bwfvf_pkg::S_MUL_X4;
      end
      bwfvf_pkg::S_MUL_X4: begin
        cmd.op = bwfvf_pkg::OP_MUL_X4; state_nxt = bwfvf_pkg::S_SET_X4;
      end
      bwfvf_pkg::S_SET_X4: begin
        cmd.op = bwfvf_pkg::OP_SET_X4; state_nxt = bwfvf_pkg::S_MUL_HH;
      end
      bwfvf_pkg::S_MUL_HH: begin
        cmd.op = bwfvf_pkg::OP_MUL_HH; state_nxt = bwfvf_pkg::S_ACC_HH;
      end
      bwfvf_pkg::S_ACC_HH: begin
        cmd.op = bwfvf_pkg::OP_ACC_HH; state_nxt = bwfvf_pkg::S_MUL_HL;
      end
      bwfvf_pkg::S_MUL_HL: begin
        cmd.op = bwfvf_pkg::OP_MUL_HL; state_nxt = bwfvf_pkg::S_ACC_HL;
      end
      bwfvf_pkg::S_ACC_HL: begin
        cmd.op = bwfvf_pkg::OP_ACC_HL; state_nxt = bwfvf_pkg::S_MUL_LL;
      end
      bwfvf_pkg::S_MUL_LL: begin
        cmd.op = bwfvf_pkg::OP_MUL_LL; state_nxt = bwfvf_pkg::S_ACC_LL;
      end
      bwfvf_pkg::S_ACC_LL: begin
        cmd.op    = bwfvf_pkg::OP_ACC_LL;
        cnt_nxt   = '0;
        state_nxt = bwfvf_pkg::S_DIV;
      end
      bwfvf_pkg::S_DIV: begin
        cmd.op = bwfvf_pkg::OP_DIV_STEP;
        if (cnt_r == bwfvf_pkg::CNT_W'(bwfvf_pkg::QW - 1)) begin
          state_nxt = bwfvf_pkg::S_SQRT_INIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      bwfvf_pkg::S_SQRT_INIT: begin
        cmd.op    = bwfvf_pkg::OP_SQRT_INIT;
        cnt_nxt   = '0;
        state_nxt = bwfvf_pkg::S_SQRT;
      end
      bwfvf_pkg::S_SQRT: begin
        cmd.op = bwfvf_pkg::OP_SQRT_STEP;
        if (cnt_r == bwfvf_pkg::CNT_W'(bwfvf_pkg::GAIN_FRAC_BITS)) begin
          state_nxt = bwfvf_pkg::S_GAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      bwfvf_pkg::S_GAIN: begin
        cmd.op = bwfvf_pkg::OP_GAIN;
        if (!pass_r && stat.mode_bp) begin
          pass_nxt  = 1'b1;
          state_nxt = bwfvf_pkg::S_MUL_X;
        end else begin
          state_nxt = bwfvf_pkg::S_MUL_RE;
        end
      end
      bwfvf_pkg::S_MUL_RE: begin
        cmd.op = bwfvf_pkg::OP_MUL_RE; state_nxt = bwfvf_pkg::S_SET_RE;
      end
      bwfvf_pkg::S_SET_RE: begin
        cmd.op = bwfvf_pkg::OP_SET_RE; state_nxt = bwfvf_pkg::S_MUL_IM;
      end
      bwfvf_pkg::S_MUL_IM: begin
        cmd.op = bwfvf_pkg::OP_MUL_IM; state_nxt = bwfvf_pkg::S_OUT;
      end
      bwfvf_pkg::S_OUT: begin
        // hold until the result register frees up
        if (!stat.out_busy) begin
          cmd.op    = bwfvf_pkg::OP_OUT;
          state_nxt = bwfvf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bwfvf_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/bwfvf_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bwfvf_dp
// Datapath: config, position counters, shared multiplier, divider, root, output.
// ----------------------------------------------------------------------------
module bwfvf_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [1:0]                             cfg_index,
  input  wire logic [bwfvf_pkg::CFG_W-1:0]            cfg_data,
  input  wire logic signed [bwfvf_pkg::COEF_W-1:0]    in_coef_re,
  input  wire logic signed [bwfvf_pkg::COEF_W-1:0]    in_coef_im,
  input  wire bwfvf_pkg::dp_cmd_t                     cmd,
  output bwfvf_pkg::dp_stat_t                         stat,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [bwfvf_pkg::COEF_W-1:0]         out_filt_re,
  output logic signed [bwfvf_pkg::COEF_W-1:0]         out_filt_im,
  output logic                                        out_volume_end
);

  localparam int F = bwfvf_pkg::GAIN_FRAC_BITS;

  logic [bwfvf_pkg::GRID_W-1:0]          grid_r;
  logic                                  mode_r;
  logic [bwfvf_pkg::CFG_W-1:0]           hi_inv_r, lo_inv_r;
  logic [bwfvf_pkg::POS_W-1:0]           plane_r, row_r, col_r;

  logic signed [bwfvf_pkg::COEF_W-1:0]   coef_re_r, coef_im_r, re_r;
  logic [bwfvf_pkg::R2_W-1:0]            r2_r;
  logic signed [bwfvf_pkg::PROD_W-1:0]   prod_r;
  logic [bwfvf_pkg::T_W-1:0]             t_r;
  logic [bwfvf_pkg::D_W-1:0]             acc_r, rem_r;
  logic [bwfvf_pkg::QW-1:0]              q_r;
  logic [bwfvf_pkg::SQ_W-1:0]            sv_r, sres_r, sbit_r;
  logic signed [bwfvf_pkg::GAIN_W-1:0]   gain_r;

  logic                                  out_valid_r;
  logic signed [bwfvf_pkg::COEF_W-1:0]   out_re_r, out_im_r;
  logic                                  out_end_r;

  logic [bwfvf_pkg::GRID_W-1:0]          n_eff;
  logic [bwfvf_pkg::GRID_W-1:0]          last_col, last_row;
  logic signed [bwfvf_pkg::FREQ_W-1:0]   fk, fj, fi;
  logic signed [bwfvf_pkg::R2_W-1:0]     fk_w, fj_w, fi_w;
  logic [bwfvf_pkg::R2_W-1:0]            r2_calc;
  logic                                  col_last, row_last, plane_last;
  logic signed [bwfvf_pkg::MUL_W-1:0]    mul_a, mul_b;
  logic [63:0]                           pu;
  logic [bwfvf_pkg::T_W-1:0]             ah, al;
  logic [bwfvf_pkg::D_W:0]               rem2;
  logic [bwfvf_pkg::SQ_W-1:0]            trial;
  logic [bwfvf_pkg::CFG_W-1:0]           inv_sel;

  function automatic logic signed [bwfvf_pkg::FREQ_W-1:0] freq_of(
      input logic [bwfvf_pkg::POS_W-1:0] p, input logic [bwfvf_pkg::GRID_W-1:0] n);
    logic signed [bwfvf_pkg::FREQ_W-1:0] ps;
    ps = $signed({2'b00, p});
    if ({1'b0, p} <= (n >> 1)) begin
      freq_of = ps;
    end else begin
      freq_of = ps - $signed({1'b0, n});
    end
  endfunction

  always_comb begin
    if (grid_r < bwfvf_pkg::GRID_W'(2)) begin
      n_eff = bwfvf_pkg::GRID_W'(2);
    end else if (grid_r > bwfvf_pkg::GRID_W'(bwfvf_pkg::MAX_GRID)) begin
      n_eff = bwfvf_pkg::GRID_W'(bwfvf_pkg::MAX_GRID);
    end else begin
      n_eff = grid_r;
    end
    last_col   = n_eff >> 1;
    last_row   = n_eff - 1'b1;
    fk         = freq_of(plane_r, n_eff);
    fj         = freq_of(row_r, n_eff);
    fi         = $signed({2'b00, col_r});
    // widen before squaring so each square keeps its full range
    fk_w       = bwfvf_pkg::R2_W'(fk);
    fj_w       = bwfvf_pkg::R2_W'(fj);
    fi_w       = bwfvf_pkg::R2_W'(fi);
    r2_calc    = $unsigned(fk_w * fk_w + fj_w * fj_w + fi_w * fi_w);
    col_last   = ({1'b0, col_r} >= last_col);
    row_last   = ({1'b0, row_r} >= last_row);
    plane_last = ({1'b0, plane_r} >= last_row);
  end

  assign inv_sel = cmd.sel_low ? lo_inv_r : hi_inv_r;
  assign pu      = prod_r[63:0];
  assign ah      = bwfvf_pkg::T_W'(t_r >> 16);
  assign al      = {17'd0, t_r[15:0]};
  assign rem2    = {rem_r, 1'b0};
  assign trial   = sres_r + sbit_r;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      bwfvf_pkg::OP_MUL_X: begin
        mul_a = $signed(bwfvf_pkg::MUL_W'(r2_r));
        mul_b = $signed(bwfvf_pkg::MUL_W'(inv_sel));
      end
      bwfvf_pkg::OP_MUL_X2, bwfvf_pkg::OP_MUL_X4: begin
        mul_a = $signed(t_r);
        mul_b = $signed(t_r);
      end
      bwfvf_pkg::OP_MUL_HH: begin
        mul_a = $signed(ah);
        mul_b = $signed(ah);
      end
      bwfvf_pkg::OP_MUL_HL: begin
        mul_a = $signed(ah);
        mul_b = $signed(al);
      end
      bwfvf_pkg::OP_MUL_LL: begin
        mul_a = $signed(al);
        mul_b = $signed(al);
      end
      bwfvf_pkg::OP_MUL_RE: begin
        mul_a = bwfvf_pkg::MUL_W'(coef_re_r);
        mul_b = bwfvf_pkg::MUL_W'(gain_r);
      end
      bwfvf_pkg::OP_MUL_IM: begin
        mul_a = bwfvf_pkg::MUL_W'(coef_im_r);
        mul_b = bwfvf_pkg::MUL_W'(gain_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // hold the product while the sequencer waits for the result register
  always_ff @(posedge clk) begin
    if (cmd.op != bwfvf_pkg::OP_NONE) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // control: config, counters, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r      <= bwfvf_pkg::GRID_W'(256);
      mode_r      <= 1'b0;
      hi_inv_r    <= 32'd16777216;
      lo_inv_r    <= 32'd16777216;
      plane_r     <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == bwfvf_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          bwfvf_pkg::REG_GRID_SIZE: begin
            grid_r  <= cfg_data[bwfvf_pkg::GRID_W-1:0];
            plane_r <= '0;
            row_r   <= '0;
            col_r   <= '0;
          end
          bwfvf_pkg::REG_FILTER_MODE: mode_r   <= cfg_data[0];
          bwfvf_pkg::REG_HIGH_CUT:    hi_inv_r <= cfg_data;
          bwfvf_pkg::REG_LOW_CUT:     lo_inv_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.op == bwfvf_pkg::OP_OUT) begin
        // advance raster position
        if (col_last) begin
          col_r <= '0;
          if (row_last) begin
            row_r <= '0;
            if (plane_last) begin
              plane_r <= '0;
            end else begin
              plane_r <= plane_r + 1'b1;
            end
          end else begin
            row_r <= row_r + 1'b1;
          end
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      bwfvf_pkg::OP_LOAD: begin
        coef_re_r <= in_coef_re;
        coef_im_r <= in_coef_im;
        r2_r      <= r2_calc;
      end
      bwfvf_pkg::OP_SET_X: begin
        if (pu > 64'd268435456) begin
          t_r <= bwfvf_pkg::T_W'(268435456);
        end else begin
          t_r <= pu[bwfvf_pkg::T_W-1:0];
        end
      end
      bwfvf_pkg::OP_SET_X2: t_r <= bwfvf_pkg::T_W'((pu + 64'd134217728) >> 28);
      bwfvf_pkg::OP_SET_X4: t_r <= bwfvf_pkg::T_W'((pu + 64'd8388608) >> 24);
      bwfvf_pkg::OP_ACC_HH: acc_r <= bwfvf_pkg::D_W'(64'd65536 + (pu << 16));
      bwfvf_pkg::OP_ACC_HL: acc_r <= acc_r + bwfvf_pkg::D_W'(pu << 1);
      bwfvf_pkg::OP_ACC_LL: begin
        acc_r <= acc_r + bwfvf_pkg::D_W'((pu + 64'd32768) >> 16);
        rem_r <= bwfvf_pkg::D_W'(32768);
        q_r   <= '0;
      end
      bwfvf_pkg::OP_DIV_STEP: begin
        if (rem2 >= {1'b0, acc_r}) begin
          rem_r <= bwfvf_pkg::D_W'(rem2 - {1'b0, acc_r});
          q_r   <= {q_r[bwfvf_pkg::QW-2:0], 1'b1};
        end else begin
          rem_r <= rem2[bwfvf_pkg::D_W-1:0];
          q_r   <= {q_r[bwfvf_pkg::QW-2:0], 1'b0};
        end
      end
      bwfvf_pkg::OP_SQRT_INIT: begin
        sv_r   <= {1'b0, q_r};
        sres_r <= '0;
        sbit_r <= bwfvf_pkg::SQ_W'(1) << (2 * F);
      end
      bwfvf_pkg::OP_SQRT_STEP: begin
        if (sv_r >= trial) begin
          sv_r   <= sv_r - trial;
          sres_r <= (sres_r >> 1) + sbit_r;
        end else begin
          sres_r <= sres_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
      end
      bwfvf_pkg::OP_GAIN: begin
        if (cmd.sel_low) begin
          gain_r <= gain_r - $signed({1'b0, sres_r[F:0]});
        end else begin
          gain_r <= $signed({1'b0, sres_r[F:0]});
        end
      end
      bwfvf_pkg::OP_SET_RE: re_r <= bwfvf_pkg::scale_sat(prod_r);
      bwfvf_pkg::OP_OUT: begin
        out_re_r  <= re_r;
        out_im_r  <= bwfvf_pkg::scale_sat(prod_r);
        out_end_r <= col_last && row_last && plane_last;
      end
      default: begin
      end
    endcase
  end

  assign stat.mode_bp  = mode_r;
  assign stat.out_busy = out_valid_r && out_stall;

  assign out_valid      = out_valid_r;
  assign out_filt_re    = out_re_r;
  assign out_filt_im    = out_im_r;
  assign out_volume_end = out_end_r;

endmodule
`default_nettype wire

/* src/butterworth_fourier_volume_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// Each coefficient runs through the bit-serial divider (33 steps) and the
//   bit-serial square root (17 steps), once per gain: once in low-pass mode,
//   twice in band-pass mode. A new beat is not taken until the last one leaves
//   the sequencer; the next beat is taken as soon as the sequencer returns to
//   idle, even while the result waits.
// Reset (synchronous, rst_n low): config registers to defaults, counters to zero.
// ----------------------------------------------------------------------------
// butterworth_fourier_volume_filter
// Scales half-complex 3D Fourier coefficients by an order-8 Butterworth gain.
// ----------------------------------------------------------------------------
module butterworth_fourier_volume_filter (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration write port
  input  wire logic                                 cfg_we,
  input  wire logic [1:0]                           cfg_index,
  input  wire logic [bwfvf_pkg::CFG_W-1:0]          cfg_data,
  // coefficient input, one beat per coefficient in raster order
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [bwfvf_pkg::COEF_W-1:0]  in_coef_re,
  input  wire logic signed [bwfvf_pkg::COEF_W-1:0]  in_coef_im,
  // filtered output
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [bwfvf_pkg::COEF_W-1:0]       out_filt_re,
  output logic signed [bwfvf_pkg::COEF_W-1:0]       out_filt_im,
  output logic                                      out_volume_end
);

  // The sequencer walks each beat through: ratio x = r2 * inv (capped at 16),
  // x^2, x^4 and x^8 on one shared multiplier, then 2^48 / (1 + x^8) one
  // quotient bit a cycle, then its integer root one bit a cycle. Band-pass
  // runs that gain pass twice and subtracts the low-cutoff gain.
  bwfvf_pkg::dp_cmd_t  cmd;
  bwfvf_pkg::dp_stat_t stat;

  bwfvf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath holds config, raster counters and the output register, so a
  // finished result can wait on out_stall while the next beat is accepted.
  bwfvf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_coef_re     (in_coef_re),
    .in_coef_im     (in_coef_im),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_filt_re    (out_filt_re),
    .out_filt_im    (out_filt_im),
    .out_volume_end (out_volume_end)
  );

endmodule
`default_nettype wire

/* bench/butterworth_fourier_volume_filter_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Butterworth Fourier volume filter testbench
// Drives coefficient beats in raster order across several grid sizes, cutoffs
// and both filter modes, predicts every filtered beat with a local gain model
// and compares each result beat field by field, in order.
// ----------------------------------------------------------------------------
module butterworth_fourier_volume_filter_test;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  bwfvf_pkg::reg_idx_t cfg_index = bwfvf_pkg::REG_GRID_SIZE;
  logic [bwfvf_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [bwfvf_pkg::COEF_W-1:0] in_coef_re = '0;
  logic signed [bwfvf_pkg::COEF_W-1:0] in_coef_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [bwfvf_pkg::COEF_W-1:0] out_filt_re;
  logic signed [bwfvf_pkg::COEF_W-1:0] out_filt_im;
  logic out_volume_end;

  butterworth_fourier_volume_filter uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_coef_re(in_coef_re), .in_coef_im(in_coef_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_filt_re(out_filt_re), .out_filt_im(out_filt_im),
    .out_volume_end(out_volume_end)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               vend;
  } filt_beat_t;

  // Shadow of the block's registers and raster counters.
  logic [9:0]  m_grid = 10'd256;
  logic        m_bandpass = 1'b0;
  logic [31:0] m_hi_inv = 32'd16777216;
  logic [31:0] m_lo_inv = 32'd16777216;
  int unsigned m_plane = 0, m_row = 0, m_col = 0;

  filt_beat_t expected_beats[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_sent = 0, n_checked = 0, n_errors = 0, n_volumes = 0;

  // Integer square root, floor.
  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Order-8 Butterworth gain, unsigned Q1.16, for squared radius r2.
  function automatic longint butterworth_gain(input longint unsigned r2,
                                              input logic [31:0] inv);
    longint unsigned x, x2, x4, ah, al, x8, d, num, m;
    x = r2 * inv;
    if (x > (64'd16 << 24)) x = 64'd16 << 24;
    x2 = (x * x + (64'd1 << 27)) >> 28;
    x4 = (x2 * x2 + (64'd1 << 23)) >> 24;
    ah = x4 >> 16;
    al = x4 & 64'hFFFF;
    x8 = ((ah * ah) << 16) + 2 * ah * al + ((al * al + 64'h8000) >> 16);
    d = x8 + (64'd1 << 16);
    num = 64'd1 << (2 * bwfvf_pkg::GAIN_FRAC_BITS + 15);
    m = (num / d) * 2 + (((num % d) * 2 >= d) ? 1 : 0);
    return longint'(int_root(m));
  endfunction

  // Coefficient times gain, rounded half up, saturated to 32 bits.
  function automatic logic signed [31:0] apply_gain(input logic signed [31:0] c,
                                                    input longint g);
    longint v, q;
    v = longint'(c) * g + (64'sd1 <<< (bwfvf_pkg::GAIN_FRAC_BITS - 1));
    q = v >>> bwfvf_pkg::GAIN_FRAC_BITS;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic longint wrap_freq(input int unsigned p, input int unsigned n);
    if (p <= n / 2) return longint'(p);
    return longint'(p) - longint'(n);
  endfunction

  // Predict one beat and advance the raster counters.
  function automatic filt_beat_t predict_filtered(input logic signed [31:0] re,
                                                  input logic signed [31:0] im);
    int unsigned n;
    longint k, j, i, g;
    longint unsigned r2;
    filt_beat_t b;
    n = m_grid;
    if (n < 2) n = 2;
    if (n > bwfvf_pkg::MAX_GRID) n = bwfvf_pkg::MAX_GRID;
    k = wrap_freq(m_plane, n);
    j = wrap_freq(m_row, n);
    i = m_col;
    r2 = longint'(k * k + j * j + i * i);
    g = butterworth_gain(r2, m_hi_inv);
    if (m_bandpass) g -= butterworth_gain(r2, m_lo_inv);
    b.re = apply_gain(re, g);
    b.im = apply_gain(im, g);
    b.vend = (m_col >= n / 2) && (m_row >= n - 1) && (m_plane >= n - 1);
    if (m_col >= n / 2) begin
      m_col = 0;
      if (m_row >= n - 1) begin
        m_row = 0;
        if (m_plane >= n - 1) m_plane = 0;
        else m_plane++;
      end else begin
        m_row++;
      end
    end else begin
      m_col++;
    end
    return b;
  endfunction

  // Drive receiver stall at the falling edge, check beats at the rising edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    filt_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected beat re=%0d im=%0d", out_filt_re, out_filt_im);
      end else begin
        e = expected_beats.pop_front();
        n_checked++;
        if (out_volume_end) n_volumes++;
        if (out_filt_re !== e.re || out_filt_im !== e.im || out_volume_end !== e.vend) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch beat %0d: exp re=%0d im=%0d end=%0b got re=%0d im=%0d end=%0b",
                     n_checked, e.re, e.im, e.vend, out_filt_re, out_filt_im, out_volume_end);
        end
      end
    end
  end

  // Send one coefficient beat; hold until accepted.
  task automatic send_coef(input logic signed [31:0] re, input logic signed [31:0] im);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_coef_re <= re;
    in_coef_im <= im;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_beats.push_back(predict_filtered(re, im));
    n_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait for every expected beat, then let the pipeline settle.
  task automatic drain;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  // Write one register while idle; grid writes also clear the counters.
  task automatic write_reg(input bwfvf_pkg::reg_idx_t idx, input logic [31:0] val);
    cfg_we = 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      bwfvf_pkg::REG_GRID_SIZE: begin
        m_grid = val[9:0];
        m_plane = 0; m_row = 0; m_col = 0;
      end
      bwfvf_pkg::REG_FILTER_MODE: m_bandpass = val[0];
      bwfvf_pkg::REG_HIGH_CUT:    m_hi_inv = val;
      bwfvf_pkg::REG_LOW_CUT:     m_lo_inv = val;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_inv();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFFFFFF;
      2: return $urandom;
      default: return $urandom_range(32'h0200_0000, 32'h0001_0000);
    endcase
  endfunction

  // Extremes of the coefficient fields, zero cutoff and a huge ratio.
  task automatic test_directed;
    write_reg(bwfvf_pkg::REG_GRID_SIZE, 32'd4);
    write_reg(bwfvf_pkg::REG_FILTER_MODE, 32'd0);
    write_reg(bwfvf_pkg::REG_HIGH_CUT, 32'd0);
    send_coef(32'sh7FFFFFFF, 32'sh80000000);
    send_coef(32'sh80000000, 32'sh7FFFFFFF);
    send_coef(32'sd0, -32'sd1);
    drain;
    write_reg(bwfvf_pkg::REG_HIGH_CUT, 32'hFFFFFFFF);
    send_coef(32'sh7FFFFFFF, 32'sh80000000);
    send_coef(32'sd1, -32'sd1);
    send_coef(32'sh55555555, 32'shAAAAAAAA);
    drain;
    // Band-pass with low cutoff above and below the high one: gain can go negative.
    write_reg(bwfvf_pkg::REG_FILTER_MODE, 32'd1);
    write_reg(bwfvf_pkg::REG_HIGH_CUT, 32'h0040_0000);
    write_reg(bwfvf_pkg::REG_LOW_CUT, 32'h0400_0000);
    repeat (6) send_coef(rand_coef(), rand_coef());
    drain;
    write_reg(bwfvf_pkg::REG_LOW_CUT, 32'h0001_0000);
    repeat (6) send_coef(32'sh7FFFFFFF, 32'sh80000000);
    drain;
  endtask

  // Clamped grid sizes: below 2 and above the maximum; grid 0 runs through a full wrap.
  task automatic test_grid_clamp;
    write_reg(bwfvf_pkg::REG_FILTER_MODE, 32'd0);
    write_reg(bwfvf_pkg::REG_HIGH_CUT, 32'h0080_0000);
    write_reg(bwfvf_pkg::REG_GRID_SIZE, 32'd0);
    repeat (9) send_coef(rand_coef(), rand_coef());
    drain;
    write_reg(bwfvf_pkg::REG_GRID_SIZE, 32'd1);
    repeat (5) send_coef(rand_coef(), rand_coef());
    drain;
    write_reg(bwfvf_pkg::REG_GRID_SIZE, 32'h3FF);
    repeat (20) send_coef(rand_coef(), rand_coef());
    drain;
  endtask

  // Random volumes with random cutoffs; mostly small grids.
  task automatic test_random(input int n_items);
    int left, sz, cnt;
    left = n_items;
    while (left > 0) begin
      drain;
      sz = ($urandom_range(9) == 0) ? $urandom_range(1023) : 2 * $urandom_range(1, 4);
      write_reg(bwfvf_pkg::REG_GRID_SIZE, 32'(sz));
      write_reg(bwfvf_pkg::REG_FILTER_MODE, $urandom_range(1));
      write_reg(bwfvf_pkg::REG_HIGH_CUT, rand_inv());
      write_reg(bwfvf_pkg::REG_LOW_CUT, rand_inv());
      cnt = $urandom_range(20, 150);
      if (cnt > left) cnt = left;
      repeat (cnt) send_coef(rand_coef(), rand_coef());
      left -= cnt;
    end
    drain;
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed;
    test_grid_clamp;
    send_idle_pct = 36; recv_idle_pct = 52;
    test_random(600);
    send_idle_pct = 52; recv_idle_pct = 36;
    test_random(600);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(600);
    $display("covered %0d coefficient beats, %0d checked, %0d volume ends, %0d mismatches",
             n_sent, n_checked, n_volumes, n_errors);
    if (n_errors == 0 && expected_beats.size() == 0) begin
      $display("butterworth_fourier_volume_filter_test: PASS");
    end else begin
      $display("butterworth_fourier_volume_filter_test: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("butterworth_fourier_volume_filter_test: FAIL");
    $finish;
  end

endmodule
